/* rtl/tcpsm_pkg.sv */
// Package: shared types, flag masks and opcodes of the TCP connection state machine.
`timescale 1ns / 1ps

package tcpsm_pkg;

    localparam logic [7:0] FLAG_FIN = 8'h01;
    localparam logic [7:0] FLAG_SYN = 8'h02;
    localparam logic [7:0] FLAG_PSH = 8'h08;
    localparam logic [7:0] FLAG_ACK = 8'h10;

    localparam logic [1:0] OP_SEGMENT = 2'd0;
    localparam logic [1:0] OP_LISTEN  = 2'd1;
    localparam logic [1:0] OP_CONNECT = 2'd2;
    localparam logic [1:0] OP_SEND    = 2'd3;

    localparam logic REG_LOCAL_PORT   = 1'b0;
    localparam logic REG_INITIAL_SEQ  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLOSED    = 4'd0,
        ST_LISTEN    = 4'd1,
        ST_SYNSENT   = 4'd2,
        ST_SYNRCVD   = 4'd3,
        ST_ESTAB     = 4'd4,
        ST_FINWAIT1  = 4'd5,
        ST_FINWAIT2  = 4'd6,
        ST_CLOSEWAIT = 4'd7,
        ST_CLOSING   = 4'd8,
        ST_LASTACK   = 4'd9,
        ST_TIMEWAIT  = 4'd10
    } state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] dest_port;
        logic [7:0]  seg_flags;
        logic [31:0] seg_seq;
        logic [31:0] seg_ack_num;
        logic [15:0] payload_len;
    } cmd_t;

    typedef struct packed {
        logic        seg_valid;
        logic [7:0]  out_flags;
        logic [31:0] out_seq;
        logic [31:0] out_ack;
        logic [15:0] out_len;
        logic [15:0] delivered_len;
        logic [3:0]  conn_state;
        logic        last;
    } res_t;

    // Results of one request: one or two result items.
    typedef struct packed {
        res_t first;
        res_t second;
        logic two;
    } pair_t;

    typedef struct packed {
        logic [15:0] local_port;
        logic [31:0] initial_local_seq;
    } cfg_t;

endpackage

/* rtl/tcpsm_cfg.sv */
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps

module tcpsm_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output tcpsm_pkg::cfg_t    cfg
);
    import tcpsm_pkg::*;

    logic [15:0] local_port_reg;
    logic [31:0] initial_seq_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_port_reg  <= 16'd0;
            initial_seq_reg <= 32'd0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_LOCAL_PORT:  local_port_reg  <= pwdata[15:0];
                REG_INITIAL_SEQ: initial_seq_reg <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_LOCAL_PORT:  prdata = {16'd0, local_port_reg};
            REG_INITIAL_SEQ: prdata = initial_seq_reg;
        endcase
    end

    assign cfg.local_port        = local_port_reg;
    assign cfg.initial_local_seq = initial_seq_reg;

endmodule

/* rtl/tcpsm_core.sv */
// Connection state, sequence registers and the per-request transition logic.
`timescale 1ns / 1ps

module tcpsm_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  tcpsm_pkg::cmd_t  cmd,
    input  tcpsm_pkg::cfg_t  cfg,
    output tcpsm_pkg::pair_t pair
);
    import tcpsm_pkg::*;

    state_t      state_reg, state_next;
    logic [31:0] local_seq_reg, local_seq_next;
    logic [31:0] remote_seq_reg, remote_seq_next;

    logic syn, ack, fin, psh, seg_ok;
    logic [31:0] seq_plus1, seq_plus_len;

    assign syn    = (cmd.seg_flags & FLAG_SYN) != 8'd0;
    assign ack    = (cmd.seg_flags & FLAG_ACK) != 8'd0;
    assign fin    = (cmd.seg_flags & FLAG_FIN) != 8'd0;
    assign psh    = (cmd.seg_flags & FLAG_PSH) != 8'd0;
    assign seg_ok = (cmd.opcode == OP_SEGMENT) && (cmd.dest_port == cfg.local_port);

    assign seq_plus1    = cmd.seg_seq + 32'd1;
    assign seq_plus_len = cmd.seg_seq + {16'd0, cmd.payload_len};

    // Next state and sequence numbers.
    always_comb
    begin
        state_next      = state_reg;
        local_seq_next  = local_seq_reg;
        remote_seq_next = remote_seq_reg;
        if (cmd.opcode == OP_LISTEN)
        begin
            state_next     = ST_LISTEN;
            local_seq_next = cfg.initial_local_seq;
        end
        else if (cmd.opcode == OP_CONNECT)
        begin
            state_next     = ST_SYNSENT;
            local_seq_next = cfg.initial_local_seq + 32'd1;
        end
        else if (seg_ok)
        begin
            unique case (state_reg)
                ST_LISTEN:
                begin
                    if (syn)
                    begin
                        remote_seq_next = seq_plus1;
                        state_next      = ST_SYNRCVD;
                    end
                end
                ST_SYNSENT:
                begin
                    if (syn)
                    begin
                        remote_seq_next = seq_plus1;
                        state_next      = ack ? ST_ESTAB : ST_SYNRCVD;
                    end
                end
                ST_SYNRCVD:
                begin
                    if (ack)
                    begin
                        local_seq_next = cmd.seg_ack_num;
                        state_next     = ST_ESTAB;
                    end
                end
                ST_ESTAB:
                begin
                    priority if (psh && ack)
                    begin
                        local_seq_next  = cmd.seg_ack_num;
                        remote_seq_next = seq_plus_len;
                    end
                    else if (fin && ack)
                    begin
                        remote_seq_next = seq_plus1;
                        state_next      = ST_LASTACK;
                    end
                    else if (ack)
                    begin
                        local_seq_next = cmd.seg_ack_num;
                    end
                    else
                    begin
                    end
                end
                ST_FINWAIT1:
                begin
                    priority if (ack)
                    begin
                        state_next = ST_FINWAIT2;
                    end
                    else if (fin)
                    begin
                        remote_seq_next = seq_plus1;
                        state_next      = ST_CLOSING;
                    end
                    else
                    begin
                    end
                end
                ST_FINWAIT2:
                begin
                    if (fin)
                        state_next = ST_CLOSED;
                end
                ST_CLOSING, ST_LASTACK:
                begin
                    if (ack)
                        state_next = ST_CLOSED;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result items; replies to received segments carry the updated sequence numbers.
    always_comb
    begin
        pair = '0;
        if (cmd.opcode == OP_CONNECT)
        begin
            pair.first.seg_valid = 1'b1;
            pair.first.out_flags = FLAG_SYN;
            pair.first.out_seq   = cfg.initial_local_seq;
        end
        else if (cmd.opcode == OP_SEND)
        begin
            if (state_reg == ST_ESTAB)
            begin
                pair.first.seg_valid     = 1'b1;
                pair.first.out_flags     = FLAG_PSH | FLAG_ACK;
                pair.first.out_seq       = local_seq_reg;
                pair.first.out_ack       = remote_seq_reg;
                pair.first.out_len       = cmd.payload_len;
                pair.first.delivered_len = cmd.payload_len;
            end
        end
        else if (seg_ok)
        begin
            pair.first.out_seq = local_seq_next;
            pair.first.out_ack = remote_seq_next;
            unique case (state_reg)
                ST_LISTEN:
                begin
                    if (syn)
                    begin
                        pair.first.seg_valid = 1'b1;
                        pair.first.out_flags = FLAG_ACK | FLAG_SYN;
                    end
                end
                ST_SYNSENT:
                begin
                    if (syn)
                    begin
                        pair.first.seg_valid = 1'b1;
                        pair.first.out_flags = FLAG_ACK;
                    end
                end
                ST_ESTAB:
                begin
                    priority if (psh && ack)
                    begin
                        pair.first.seg_valid     = 1'b1;
                        pair.first.out_flags     = FLAG_ACK;
                        pair.first.delivered_len = cmd.payload_len;
                    end
                    else if (fin && ack)
                    begin
                        pair.first.seg_valid  = 1'b1;
                        pair.first.out_flags  = FLAG_ACK;
                        pair.two              = 1'b1;
                        pair.second.seg_valid = 1'b1;
                        pair.second.out_flags = FLAG_FIN;
                        pair.second.out_seq   = local_seq_next;
                        pair.second.out_ack   = remote_seq_next;
                    end
                    else
                    begin
                    end
                end
                ST_FINWAIT1:
                begin
                    if (!ack && fin)
                    begin
                        pair.first.seg_valid = 1'b1;
                        pair.first.out_flags = FLAG_ACK;
                    end
                end
                default:
                begin
                end
            endcase
            // No segment: the result's sequence and acknowledgement fields read as zero.
            if (!pair.first.seg_valid)
            begin
                pair.first.out_seq = 32'd0;
                pair.first.out_ack = 32'd0;
            end
        end
        pair.first.conn_state  = state_next;
        pair.first.last        = !pair.two;
        pair.second.conn_state = state_next;
        pair.second.last       = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLOSED;
            local_seq_reg  <= 32'd0;
            remote_seq_reg <= 32'd0;
        end
        else if (fire)
        begin
            state_reg      <= state_next;
            local_seq_reg  <= local_seq_next;
            remote_seq_reg <= remote_seq_next;
        end
    end

endmodule

/* rtl/tcpsm_outq.sv */
// Two-slot result queue; each slot holds one request's results, sent one per cycle while res_stall is low.
`timescale 1ns / 1ps

module tcpsm_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tcpsm_pkg::pair_t push_pair,
    output logic             room,
    output logic             res_valid,
    input  logic             res_stall,
    output tcpsm_pkg::res_t  res
);
    import tcpsm_pkg::*;

    pair_t      slot_reg [2];
    logic [1:0] count_reg, count_next;
    logic       head_reg, head_next;
    logic       tail_reg, tail_next;
    logic       sub_reg, sub_next;
    pair_t      head_pair;
    logic       take, pop;

    assign head_pair = slot_reg[head_reg];
    assign room      = count_reg != 2'd2;
    assign res_valid = count_reg != 2'd0;
    assign res       = sub_reg ? head_pair.second : head_pair.first;
    assign take      = res_valid && !res_stall;
    // Retire the slot after its last result goes out.
    assign pop       = take && (!head_pair.two || sub_reg);

    always_comb
    begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
        head_next  = pop  ? !head_reg : head_reg;
        tail_next  = push ? !tail_reg : tail_reg;
        sub_next   = sub_reg;
        if (take)
            sub_next = !pop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            sub_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            sub_reg   <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[tail_reg] <= push_pair;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'd2 || pop))
        else $error("push into a full result queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result queue count out of range");

    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (take && head_pair.two && !sub_reg) |=> (sub_reg && res_valid))
        else $error("second result of a request was not presented");

    a_sub_only_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> (res_valid && head_pair.two))
        else $error("second-result select set on a single-result slot");

endmodule

/* rtl/tcp_connection_state_machine.sv */
// Top level: request register, connection state logic, result queue and config port.
`timescale 1ns / 1ps

// One TCP endpoint's connection state machine. Each request is a command
// (listen, connect, send) or a received segment header; each produces one
// result item, or two for a FIN with ACK in ESTABLISHED (an ACK, then a FIN).
// A request is accepted into an input register and evaluated against the
// state, local and remote sequence registers once the queue has a free slot;
// its results are written into a two-slot result queue at the end of the
// cycle in which it is evaluated, and res presents them from there. A new
// request can be taken every cycle while cmd_stall is low; sustained flow is
// bounded by the single result port, which drains the queue one result a
// cycle while res_stall is low. cmd_stall rises only while the input register
// holds a request and both queue slots are occupied. Segments whose
// destination port differs from local_port leave the state untouched.
// Write local_port (address 0) and initial_local_seq (address 4) only while
// no request is in flight.
module tcp_connection_state_machine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  tcpsm_pkg::cmd_t  cmd,
    output logic             res_valid,
    input  logic             res_stall,
    output tcpsm_pkg::res_t  res
);
    import tcpsm_pkg::*;

    cfg_t  cfg;
    cmd_t  cmd_reg;
    logic  held_reg, held_next;
    logic  room;
    logic  fire;
    logic  accept;
    pair_t pair;

    tcpsm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Evaluate the held request once the queue has a free slot.
    assign fire      = held_reg && room;
    assign cmd_stall = held_reg && !room;
    assign accept    = cmd_valid && !cmd_stall;

    always_comb
    begin
        held_next = held_reg;
        if (accept)
            held_next = 1'b1;
        else if (fire)
            held_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= 1'b0;
        else
            held_reg <= held_next;
    end

    // Hold the request payload; no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd;
    end

    tcpsm_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .cmd   (cmd_reg),
        .cfg   (cfg),
        .pair  (pair)
    );

    tcpsm_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_pair (pair),
        .room      (room),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (held_reg && !room))
        else $error("request stalled with a free queue slot");

    a_fire_leaves_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> res_valid)
        else $error("evaluated request left no result");

    a_two_ends_lastack: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && pair.two) |-> (pair.second.conn_state == ST_LASTACK))
        else $error("two results outside the passive close");

endmodule
